[src/text_console_cell_writer_macros.svh]
// ----------------------------------------------------------------------------
// Console cell writer assertion macros
// Each macro expands to a labeled concurrent assertion clocked on the rising
// edge and disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

`ifndef ASSERT_OFF

`define CCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define CCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/ccw_pkg.sv]
// ----------------------------------------------------------------------------
// Console cell writer package
// Transfer types and fixed codes shared by the console cell writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ccw_pkg;

    localparam int CELL_IDX_W = 11;
    localparam int CELL_VAL_W = 16;

    localparam logic       MODE_PUT     = 1'b0;
    localparam logic       MODE_SET     = 1'b1;
    localparam logic       ACT_WRITE    = 1'b0;
    localparam logic       ACT_CLEAR    = 1'b1;
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CELL_VAL_W-1:0] ATTR_RESET = 16'd3840;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic       to_console;
        logic [4:0] row;
        logic [6:0] column;
    } t_in_item;

    typedef struct packed {
        logic                  action;
        logic [CELL_IDX_W-1:0] cell_index;
        logic [CELL_VAL_W-1:0] cell_value;
        logic                  last;
    } t_out_item;

    // Results caused by one item: an optional row clear, then an optional write.
    typedef struct packed {
        logic                  clr;
        logic                  wr;
        logic [CELL_IDX_W-1:0] idx;
        logic [CELL_VAL_W-1:0] value;
    } t_pair;

endpackage

`default_nettype wire

[src/ccw_cursor.sv]
// ----------------------------------------------------------------------------
// Console cursor
// Holds the cursor as row, column and linear cell, and works out the results
// and the next cursor for the item in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_writer_macros.svh"

module ccw_cursor #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire ccw_pkg::t_in_item           i_item,
    input  wire logic [ccw_pkg::CELL_VAL_W-1:0] i_attr,
    output ccw_pkg::t_pair                   o_pair
);
    import ccw_pkg::*;

    localparam int RW  = $clog2(ROWS + 1);
    localparam int CW  = $clog2(COLS);
    localparam int CLW = $clog2(ROWS * COLS + 1);

    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [CLW-1:0] r_cell, n_cell;

    logic           wrap;
    logic [RW-1:0]  cur_row;
    logic [CW-1:0]  cur_col;
    logic [CLW-1:0] cur_cell;
    logic           active;
    logic           is_nl;
    logic [7:0]     row_in;
    logic [7:0]     row_eff;
    logic [8:0]     col_in;
    logic [8:0]     col_eff;
    logic [RW-1:0]  set_row;
    logic [CW-1:0]  set_col;

    // The cursor parks one row past the screen after the last cell and only
    // wraps to the top when the next console character arrives.
    assign wrap     = (r_row == RW'(ROWS));
    assign cur_row  = wrap ? '0 : r_row;
    assign cur_col  = wrap ? '0 : r_col;
    assign cur_cell = wrap ? '0 : r_cell;

    assign active = (i_item.mode == MODE_PUT) && i_item.to_console
                    && (i_item.char_code != CHAR_NUL);
    assign is_nl  = (i_item.char_code == CHAR_NEWLINE);

    assign row_in = {3'b000, i_item.row};
    assign col_in = {2'b00, i_item.column};

    always_comb begin
        if (row_in == 8'd0) begin
            row_eff = 8'd1;
        end else if (row_in > 8'(ROWS)) begin
            row_eff = 8'(ROWS);
        end else begin
            row_eff = row_in;
        end
        if (col_in == 9'd0) begin
            col_eff = 9'd1;
        end else if (col_in > 9'(COLS)) begin
            col_eff = 9'(COLS);
        end else begin
            col_eff = col_in;
        end
    end

    assign set_row = RW'(row_eff - 8'd1);
    assign set_col = CW'(col_eff - 9'd1);

    always_comb begin
        o_pair.clr   = active && (cur_col == '0);
        o_pair.wr    = active && !is_nl;
        o_pair.idx   = CELL_IDX_W'(cur_cell);
        o_pair.value = CELL_VAL_W'({8'd0, i_item.char_code}) + i_attr;
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_cell = r_cell;
        if (i_item.mode == MODE_SET) begin
            n_row  = set_row;
            n_col  = set_col;
            n_cell = CLW'(CLW'(set_row) * CLW'(COLS)) + CLW'(set_col);
        end else if (active) begin
            if (is_nl) begin
                n_row  = RW'(cur_row + 1'b1);
                n_col  = '0;
                n_cell = CLW'(cur_cell + (CLW'(COLS) - CLW'(cur_col)));
            end else begin
                n_cell = CLW'(cur_cell + 1'b1);
                if (cur_col == CW'(COLS - 1)) begin
                    n_row = RW'(cur_row + 1'b1);
                    n_col = '0;
                end else begin
                    n_row = cur_row;
                    n_col = CW'(cur_col + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_cell <= '0;
        end else if (i_advance) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_cell <= n_cell;
        end
    end

    `CCW_ASSERT_IMPL(a_row_in_range, i_clk, i_rst_n, 1'b1, r_row <= RW'(ROWS))
    `CCW_ASSERT_IMPL(a_park_col_zero, i_clk, i_rst_n, wrap, r_col == '0)
    `CCW_ASSERT_IMPL(a_cell_consistent, i_clk, i_rst_n, 1'b1,
        r_cell == CLW'(CLW'(r_row) * CLW'(COLS)) + CLW'(r_col))

endmodule

`default_nettype wire

[src/ccw_serializer.sv]
// ----------------------------------------------------------------------------
// Console result serializer
// Holds the results of one item and hands them out one transfer at a time,
// the row clear before the cell write.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_writer_macros.svh"

module ccw_serializer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire ccw_pkg::t_pair     i_pair,
    output logic                    o_free,
    output logic                    o_valid,
    output ccw_pkg::t_out_item      o_item,
    input  wire logic               i_ready
);
    import ccw_pkg::*;

    logic                  r_clr;
    logic                  r_wr;
    logic [CELL_IDX_W-1:0] r_idx;
    logic [CELL_VAL_W-1:0] r_val;
    logic                  take;

    assign o_valid = r_clr || r_wr;
    assign take    = o_valid && i_ready;

    always_comb begin
        o_item.action     = r_clr ? ACT_CLEAR : ACT_WRITE;
        o_item.cell_index = r_idx;
        o_item.cell_value = r_clr ? '0 : r_val;
        o_item.last       = r_clr ? !r_wr : 1'b1;
    end

    // A new set of results may load in the cycle the final one is taken.
    assign o_free = !o_valid || (take && o_item.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b0;
            r_wr  <= 1'b0;
        end else if (i_load) begin
            r_clr <= i_pair.clr;
            r_wr  <= i_pair.wr;
        end else if (take) begin
            if (r_clr) begin
                r_clr <= 1'b0;
            end else begin
                r_wr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_idx <= i_pair.idx;
            r_val <= i_pair.value;
        end
    end

    `CCW_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_load, o_free)
    `CCW_ASSERT_NEXT(a_clear_then_write, i_clk, i_rst_n,
        take && r_clr && r_wr && !i_load, o_valid && !r_clr)

endmodule

`default_nettype wire

[src/text_console_cell_writer.sv]
// Text console cell writer. Each accepted transfer is either a character or a
// set-position command; the block keeps a cursor over a ROWS by COLS screen
// and produces cell writes and row clears. A character in column 0 gives a
// row clear and then (unless it is a newline) a cell write; other characters
// give one cell write; newlines outside column 0, set-position commands,
// NUL and non-console characters give no result. The input register takes
// one item per cycle while the serializer is free; the result register hands
// out one result per cycle while i_out_ready is high. The user writes the
// attribute word (i_cfg_we / i_cfg_data) only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
// Text console cell writer top level
// Input register, cursor logic and result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_writer_macros.svh"

module text_console_cell_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ccw_pkg::CELL_VAL_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire ccw_pkg::t_in_item              i_in,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    output ccw_pkg::t_out_item                  o_out,
    input  wire logic                           i_out_ready
);
    import ccw_pkg::*;

    logic [CELL_VAL_W-1:0] r_attr;
    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  advance;
    logic                  free;
    logic                  in_take;
    t_pair                 pair;

    assign advance    = r_in_valid && free;
    assign o_in_ready = !r_in_valid || free;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    ccw_cursor #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_attr    (r_attr),
        .o_pair    (pair)
    );

    ccw_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_pair  (pair),
        .o_free  (free),
        .o_valid (o_out_valid),
        .o_item  (o_out),
        .i_ready (i_out_ready)
    );

    `CCW_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n,
        r_in_valid && !advance, r_in_valid && $stable(r_in))
    `CCW_ASSERT_IMPL(a_empty_takes_input, i_clk, i_rst_n, !r_in_valid, o_in_ready)

endmodule

`default_nettype wire
